// ===== hdl/indexed_shift_list_macros.svh =====
// Assertion macros shared by the indexed shift list RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef INDEXED_SHIFT_LIST_MACROS_SVH
`define INDEXED_SHIFT_LIST_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define ISL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while the active-low reset is asserted.
`define ISL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/isl_pkg.sv =====
// Package for the indexed shift list: field widths, operation and status codes,
// and the control bundle sent to every storage cell. No dependencies.
`default_nettype none

package isl_pkg;

  localparam int OP_W      = 3;
  localparam int VALUE_W   = 32;
  localparam int INDEX_W   = 4;
  localparam int STATUS_W  = 2;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AFTER = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // Per-cycle command broadcast along the row of cells.
  typedef struct packed {
    logic load;      // write the new word at the target position
    logic shift_up;  // cells above the target take their lower neighbor
    logic shift_dn;  // cells at and above the target take their upper neighbor
  } isl_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/isl_cell.sv =====
// One storage cell of the indexed shift list row.
// Depends on isl_pkg for the control bundle.
`default_nettype none

module isl_cell #(
  parameter int IDX       = 0,
  parameter int POS_W     = 5,
  parameter int DATA_BITS = 32
) (
  input  wire                          clk,
  input  wire isl_pkg::isl_ctrl_t      ctrl,
  input  wire logic [POS_W-1:0]        pos,
  input  wire logic [DATA_BITS-1:0]    load_word,
  input  wire logic [DATA_BITS-1:0]    below_word,
  input  wire logic [DATA_BITS-1:0]    above_word,
  output logic [DATA_BITS-1:0]         word
);
  import isl_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic [DATA_BITS-1:0] word_r;
  logic [DATA_BITS-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctrl.load && (pos == MY_POS)) begin
      word_nxt = load_word;
    end else if (ctrl.shift_up && (MY_POS > pos)) begin
      word_nxt = below_word;
    end else if (ctrl.shift_dn && (MY_POS >= pos)) begin
      word_nxt = above_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

`default_nettype wire

// ===== hdl/indexed_shift_list.sv =====
// Indexed shift list: a bounded ordered list of signed words held in a row of cells
// that shift up on insert and down on remove. One request per cycle, one result each.
// Request (in_tdata, 40 bits): op, value, index from bit 0 up. Result (out_tdata,
// 40 bits): status, data, count from bit 0 up. The decode, the parallel shift or
// load of all cells and the read of the indexed entry all happen in the cycle the
// request transfers, and the result lands in an output register. A new request is
// taken in the same cycle a waiting result transfers, so the block sustains one
// request per cycle while the result side keeps up. Index values at or beyond the
// count answer "index not present", inserts into a full list answer "list full";
// append only checks for a full list. Depends on isl_pkg and
// indexed_shift_list_macros.svh.
`default_nettype none

`include "indexed_shift_list_macros.svh"

module indexed_shift_list #(
  parameter int CAPACITY  = 16,
  parameter int DATA_BITS = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // op[2:0], value[34:3], index[38:35], zero pad [39]
  input  wire logic [isl_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // status[1:0], data[33:2], count[38:34], zero pad [39]
  output logic [isl_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import isl_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int NRD  = (CAPACITY < (1 << INDEX_W)) ? CAPACITY : (1 << INDEX_W);
  localparam int RDW  = $clog2(NRD);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  // Request fields.
  logic [OP_W-1:0]           req_op;
  logic signed [VALUE_W-1:0] req_value;
  logic [INDEX_W-1:0]        req_index;
  logic                      in_fire;

  assign req_op    = in_tdata[OP_W-1:0];
  assign req_value = in_tdata[OP_W+VALUE_W-1:OP_W];
  assign req_index = in_tdata[OP_W+VALUE_W+INDEX_W-1:OP_W+VALUE_W];

  // Control state and output register.
  logic [CW-1:0]       used_r, used_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Row of cells.
  isl_ctrl_t                     ctrl;
  logic [CW-1:0]                 pos;
  logic signed [DATA_BITS-1:0]   new_word;
  logic [DATA_BITS-1:0]          words [CAPACITY];
  logic signed [DATA_BITS-1:0]   rd_words [NRD];
  logic signed [DATA_BITS-1:0]   rd_word;

  assign new_word = DATA_BITS'(req_value);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    isl_cell #(
      .IDX       (g),
      .POS_W     (CW),
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (pos),
      .load_word  (new_word),
      .below_word (words[(g == 0) ? 0 : g - 1]),
      .above_word (words[(g == CAPACITY - 1) ? g : g + 1]),
      .word       (words[g])
    );
  end

  for (genvar g = 0; g < NRD; g++) begin : g_rd
    assign rd_words[g] = words[g];
  end

  // Only the first positions are addressable; an index beyond them is already rejected.
  assign rd_word = rd_words[req_index[RDW-1:0]];

  logic idx_missing;
  logic is_full;

  assign idx_missing = CMPW'(req_index) >= CMPW'(used_r);
  assign is_full     = used_r == FULL_COUNT;

  always_comb begin
    ctrl           = '0;
    pos            = used_r;
    used_nxt       = used_r;
    out_status_nxt = ST_DONE;
    out_data_nxt   = '0;
    case (req_op)
      OP_APPEND: begin
        if (is_full) begin
          out_status_nxt = ST_FULL;
        end else begin
          ctrl.load = 1'b1;
          used_nxt  = used_r + 1'b1;
        end
      end
      OP_INS_AT, OP_INS_AFTER: begin
        if (idx_missing) begin
          out_status_nxt = ST_NO_INDEX;
        end else if (is_full) begin
          out_status_nxt = ST_FULL;
        end else begin
          pos           = (req_op == OP_INS_AT) ? CW'(req_index) : CW'(req_index) + 1'b1;
          ctrl.load     = 1'b1;
          ctrl.shift_up = 1'b1;
          used_nxt      = used_r + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (idx_missing) begin
          out_status_nxt = ST_NO_INDEX;
        end else begin
          pos           = CW'(req_index);
          ctrl.shift_dn = 1'b1;
          out_data_nxt  = DATA_W'(rd_word);
          used_nxt      = used_r - 1'b1;
        end
      end
      OP_READ: begin
        if (idx_missing) begin
          out_status_nxt = ST_NO_INDEX;
        end else begin
          out_data_nxt = DATA_W'(rd_word);
        end
      end
      default: begin
        // Unused operation codes leave the list alone and report done.
        out_status_nxt = ST_DONE;
      end
    endcase
    // Nothing moves unless the request actually transfers.
    if (!in_fire) begin
      ctrl     = '0;
      used_nxt = used_r;
    end
    out_count_nxt = COUNT_W'(used_nxt);
    out_valid_nxt = in_fire || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r <= out_status_nxt;
      out_data_r   <= out_data_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_data_r, out_status_r};

  // Checks.
  `ISL_ASSERT_IMPL(a_used_bound, clk, rst_n, 1'b1, used_r <= FULL_COUNT,
                   "entry count exceeds capacity")
  `ISL_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, in_fire, out_valid_r,
                   "accepted request produced no result")
  `ISL_ASSERT_NEXT(a_append_grows, clk, rst_n,
                   in_fire && (req_op == OP_APPEND) && !is_full,
                   used_r == $past(used_r) + 1'b1,
                   "append did not grow the list by one")
  `ISL_ASSERT_IMPL(a_full_status, clk, rst_n,
                   out_valid_r && (out_status_r == ST_FULL),
                   out_count_r == COUNT_W'(FULL_COUNT),
                   "full status reported with a list that is not full")

endmodule

`default_nettype wire

// ===== sim/indexed_shift_list_tb.sv =====
// Testbench for indexed_shift_list: drives list requests over the input stream and checks
// each result transfer against a cycle-free predictor of the list contents and count.
// Depends on isl_pkg and the indexed_shift_list RTL; needs no files or arguments at run time.
module indexed_shift_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import isl_pkg::*;

  localparam int LIST_CAPACITY = 16;
  // Op codes the block ignores; they still answer with one result.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam int MAX_REPORTED = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Predicted list contents and entry count.
  logic [DATA_W-1:0]  list_words [LIST_CAPACITY];
  logic [COUNT_W-1:0] list_len;

  list_result_t pending_results [$];
  int mismatch_count = 0;
  int send_idle_pct;
  int recv_idle_pct;

  indexed_shift_list #(
    .CAPACITY (LIST_CAPACITY),
    .DATA_BITS(DATA_W)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    if (mismatch_count < MAX_REPORTED) begin
      $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    end
    mismatch_count++;
  endtask

  // Applies one request to the predicted list and returns the result it must produce.
  function automatic list_result_t apply_list_request(logic [OP_W-1:0] op,
                                                      logic [VALUE_W-1:0] value,
                                                      logic [INDEX_W-1:0] index);
    list_result_t r;
    int pos;
    r.status = ST_DONE;
    r.data = '0;
    if (op == OP_APPEND) begin
      if (list_len >= LIST_CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        list_words[list_len] = value;
        list_len++;
      end
    end else if (op <= OP_READ) begin
      if (index >= list_len) begin
        r.status = ST_NO_INDEX;
      end else if (op == OP_INS_AT || op == OP_INS_AFTER) begin
        if (list_len >= LIST_CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = int'(index) + ((op == OP_INS_AFTER) ? 1 : 0);
          for (int i = int'(list_len); i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = value;
          list_len++;
        end
      end else begin
        r.data = list_words[index];
        if (op == OP_REMOVE) begin
          for (int i = int'(index); i + 1 < int'(list_len); i++) begin
            list_words[i] = list_words[i+1];
          end
          list_len--;
        end
      end
    end
    r.count = list_len;
    return r;
  endfunction

  // Called and returning at a falling edge; tvalid is left high so that back-to-back
  // transfers never lower and raise it in the same time step.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                              input logic [INDEX_W-1:0] index);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, index, value, op};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_list_request(op, value, index));
    @(negedge clk);
  endtask

  // Holds the sender off until every outstanding result has transferred.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(11))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Every request but append against an empty list, plus the ignored op codes.
  task automatic test_empty_list();
    send_request(OP_READ, 32'h1234_5678, 4'd0);
    send_request(OP_REMOVE, 32'h0, 4'd0);
    send_request(OP_INS_AT, 32'hDEAD_BEEF, 4'd0);
    send_request(OP_INS_AFTER, 32'hCAFE_F00D, 4'd0);
    send_request(OP_UNUSED_LO, 32'hFFFF_FFFF, 4'd15);
    send_request(OP_UNUSED_HI, 32'h5555_AAAA, 4'd15);
  endtask

  task automatic test_edge_values();
    send_request(OP_APPEND, 32'h8000_0000, 4'd15);
    send_request(OP_APPEND, 32'h7FFF_FFFF, 4'd0);
    send_request(OP_INS_AT, 32'hFFFF_FFFF, 4'd0);
    send_request(OP_INS_AFTER, 32'h0000_0000, 4'd2);
    send_request(OP_READ, 32'h0, 4'd15);
    send_request(OP_READ, 32'h0, 4'd3);
    send_request(OP_REMOVE, 32'h0, 4'd1);
  endtask

  // Fills the list, then checks that every kind of insert is refused while full.
  task automatic test_full_list();
    while (list_len < LIST_CAPACITY) send_request(OP_APPEND, pick_word(), INDEX_W'($urandom));
    send_request(OP_APPEND, 32'h1111_1111, 4'd0);
    send_request(OP_INS_AT, 32'h2222_2222, 4'd0);
    send_request(OP_INS_AFTER, 32'h3333_3333, 4'd15);
    send_request(OP_REMOVE, 32'h0, 4'd15);
    wait_drained();
  endtask

  // Random traffic that swings between growing and shrinking the list so that full and
  // empty lists come up often; a few requests use ignored op codes or wild indexes.
  task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
    int done_items;
    int swing_left;
    bit growing;
    int roll;
    logic [OP_W-1:0] op;
    logic [INDEX_W-1:0] idx;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    done_items = 0;
    swing_left = 0;
    growing = 1'b0;
    while (done_items < n_items) begin
      if (swing_left == 0) begin
        growing = ~growing;
        swing_left = $urandom_range(60, 15);
      end
      swing_left--;
      roll = $urandom_range(99);
      if (roll < 4) begin
        op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      end else begin
        roll = $urandom_range(99);
        if (growing) begin
          op = (roll < 25) ? OP_APPEND : (roll < 45) ? OP_INS_AT :
               (roll < 65) ? OP_INS_AFTER : (roll < 80) ? OP_REMOVE : OP_READ;
        end else begin
          op = (roll < 10) ? OP_APPEND : (roll < 18) ? OP_INS_AT :
               (roll < 26) ? OP_INS_AFTER : (roll < 66) ? OP_REMOVE : OP_READ;
        end
        done_items++;
      end
      if (list_len != 0 && $urandom_range(99) < 85) begin
        idx = INDEX_W'($urandom_range(int'(list_len) - 1));
      end else begin
        idx = INDEX_W'($urandom_range(15));
      end
      send_request(op, pick_word(), idx);
      if ($urandom_range(199) == 0) wait_drained();
    end
  endtask

  always @(negedge clk) begin
    out_tready <= rst_n ? ($urandom_range(99) >= recv_idle_pct) : 1'b0;
  end

  // Result fields: status [1:0], data [33:2], count [38:34].
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[1:0] !== want.status) report_mismatch("status", out_tdata[1:0], want.status);
        if (out_tdata[33:2] !== want.data) report_mismatch("data", out_tdata[33:2], want.data);
        if (out_tdata[38:34] !== want.count) report_mismatch("count", out_tdata[38:34], want.count);
      end
    end
  end

  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    send_idle_pct = 23;
    recv_idle_pct = 76;
    list_len = '0;
    foreach (list_words[i]) list_words[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_list();
    test_edge_values();
    test_full_list();
    test_random_traffic(600, 23, 76);
    test_random_traffic(600, 76, 23);
    test_random_traffic(600, 0, 0);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/isl_pkg.sv
hdl/isl_cell.sv
hdl/indexed_shift_list.sv
sim/indexed_shift_list_tb.sv
